>>> sv/rrp_pkg.sv
`default_nettype none

package rrp_pkg;

    localparam int KEY_BYTES_DEF  = 16;
    localparam int HASH_BYTES_DEF = 8;
    localparam int LEN_BITS_DEF   = 32;
    localparam int COUNT_W        = 5;

    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_N = 8'h4E;

    localparam logic [6:0] LEN_DIGIT_MASK = 7'h7F;

    localparam logic [2:0] TY_S = 3'd0;
    localparam logic [2:0] TY_P = 3'd1;
    localparam logic [2:0] TY_L = 3'd2;
    localparam logic [2:0] TY_K = 3'd3;
    localparam logic [2:0] TY_R = 3'd4;
    localparam logic [2:0] TY_N = 3'd5;

    localparam logic [1:0] FK_HASH  = 2'd0;
    localparam logic [1:0] FK_NAME  = 2'd1;
    localparam logic [1:0] FK_KEY   = 2'd2;
    localparam logic [1:0] FK_VALUE = 2'd3;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_VARINT,
        PH_BLOB,
        PH_FIXED
    } phase_t;

    typedef struct packed {
        logic       none;
        logic [1:0] kind;
    } field_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] code;
    } type_dec_t;

    typedef struct packed {
        phase_t             phase;
        logic [2:0]         type_code;
        logic [1:0]         step;
        logic [COUNT_W-1:0] count;
        logic               reject;
        logic               complete;
    } ctl_t;

    typedef struct packed {
        logic [7:0] field_byte;
        logic       field_valid;
        logic [1:0] field_kind;
        logic       field_end;
        logic       field_empty;
        logic [2:0] record_type;
        logic       message_end;
        logic       message_ok;
    } result_t;

    localparam ctl_t CTL_RESET = '{
        phase:     PH_TYPE,
        type_code: TY_S,
        step:      2'd0,
        count:     '0,
        reject:    1'b0,
        complete:  1'b0
    };

    function automatic field_t field_at(input logic [2:0] tcode, input logic [1:0] step);
        field_t f;
        f.none = 1'b1;
        f.kind = FK_HASH;
        case (tcode)
            TY_S: begin
                case (step)
                    2'd0:    begin f.none = 1'b0; f.kind = FK_HASH; end
                    2'd1:    begin f.none = 1'b0; f.kind = FK_VALUE; end
                    default: f.none = 1'b1;
                endcase
            end
            TY_P: begin
                case (step)
                    2'd0:    begin f.none = 1'b0; f.kind = FK_NAME; end
                    2'd1:    begin f.none = 1'b0; f.kind = FK_KEY; end
                    2'd2:    begin f.none = 1'b0; f.kind = FK_VALUE; end
                    default: f.none = 1'b1;
                endcase
            end
            TY_L, TY_K: begin
                case (step)
                    2'd0:    begin f.none = 1'b0; f.kind = FK_NAME; end
                    2'd1:    begin f.none = 1'b0; f.kind = FK_KEY; end
                    default: f.none = 1'b1;
                endcase
            end
            TY_R, TY_N: begin
                case (step)
                    2'd0:    begin f.none = 1'b0; f.kind = FK_NAME; end
                    default: f.none = 1'b1;
                endcase
            end
            default: f.none = 1'b1;
        endcase
        return f;
    endfunction

    function automatic type_dec_t decode_type(input logic [7:0] b);
        type_dec_t d;
        d.ok   = 1'b1;
        d.code = TY_S;
        case (b)
            CH_S:    d.code = TY_S;
            CH_P:    d.code = TY_P;
            CH_L:    d.code = TY_L;
            CH_K:    d.code = TY_K;
            CH_R:    d.code = TY_R;
            CH_N:    d.code = TY_N;
            default: d.ok = 1'b0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> sv/rrp_step.sv
`default_nettype none

module rrp_step #(
    parameter int KEY_BYTES  = rrp_pkg::KEY_BYTES_DEF,
    parameter int HASH_BYTES = rrp_pkg::HASH_BYTES_DEF,
    parameter int LEN_BITS   = rrp_pkg::LEN_BITS_DEF
) (
    input  wire rrp_pkg::ctl_t   ctl_cur,
    input  wire [LEN_BITS-1:0]   len_cur,
    input  wire [7:0]            data_byte,
    input  wire                  last_byte,
    output rrp_pkg::ctl_t        ctl_next,
    output logic [LEN_BITS-1:0]  len_next,
    output rrp_pkg::result_t     res_next
);
    import rrp_pkg::*;

    localparam logic [COUNT_W-1:0] NEED_HASH = COUNT_W'(HASH_BYTES);
    localparam logic [COUNT_W-1:0] NEED_KEY  = COUNT_W'(KEY_BYTES);

    ctl_t               c;
    logic [LEN_BITS-1:0] len;
    result_t            r;
    field_t             kind_f;
    field_t             nf;
    field_t             after_f;
    type_dec_t          td;
    logic               advance;
    logic               start;
    logic [1:0]         step_after;
    logic [COUNT_W-1:0] need;

    always_comb begin
        c          = ctl_cur;
        len        = len_cur;
        r          = '0;
        kind_f     = field_at(ctl_cur.type_code, ctl_cur.step);
        td         = decode_type(data_byte);
        advance    = 1'b0;
        start      = 1'b0;
        nf         = '0;
        after_f    = '0;
        step_after = 2'd0;
        need       = (kind_f.kind == FK_HASH) ? NEED_HASH : NEED_KEY;

        if (!c.reject && !c.complete) begin
            case (c.phase)
                PH_TYPE: begin
                    if (td.ok) begin
                        c.type_code = td.code;
                        c.step      = 2'd0;
                        start       = 1'b1;
                    end else begin
                        c.type_code = TY_S;
                        c.reject    = 1'b1;
                    end
                end
                PH_VARINT: begin
                    if (|len[LEN_BITS-1 -: 7]) begin
                        len = '1;
                    end else begin
                        len = {len[LEN_BITS-8:0], data_byte[6:0] & LEN_DIGIT_MASK};
                    end
                    if (!data_byte[7]) begin
                        if (len == '0) begin
                            r.field_end   = 1'b1;
                            r.field_empty = 1'b1;
                            r.field_kind  = kind_f.kind;
                            advance       = 1'b1;
                        end else begin
                            c.phase = PH_BLOB;
                        end
                    end
                end
                PH_BLOB: begin
                    r.field_valid = 1'b1;
                    r.field_byte  = data_byte;
                    r.field_kind  = kind_f.kind;
                    len           = len - 1'b1;
                    if (len == '0) begin
                        r.field_end = 1'b1;
                        advance     = 1'b1;
                    end
                end
                PH_FIXED: begin
                    r.field_valid = 1'b1;
                    r.field_byte  = data_byte;
                    r.field_kind  = kind_f.kind;
                    c.count       = c.count + 1'b1;
                    if (c.count >= need) begin
                        r.field_end = 1'b1;
                        advance     = 1'b1;
                    end
                end
                default: begin
                    c.reject = 1'b1;
                end
            endcase

            if (advance) begin
                c.step = c.step + 2'd1;
            end
            if (advance || start) begin
                nf = field_at(c.type_code, c.step);
                if (nf.none) begin
                    c.complete = 1'b1;
                end else if (nf.kind == FK_NAME || nf.kind == FK_VALUE) begin
                    c.phase = PH_VARINT;
                    len     = '0;
                end else begin
                    c.phase = PH_FIXED;
                    c.count = '0;
                end
            end

            // blob cut short by the end of the message
            if (last_byte && !c.reject && !c.complete && c.phase == PH_BLOB) begin
                r.field_end   = 1'b1;
                r.field_kind  = kind_f.kind;
                r.field_empty = !r.field_valid;
                step_after    = c.step + 2'd1;
                after_f       = field_at(c.type_code, step_after);
                if (after_f.none) begin
                    c.complete = 1'b1;
                end
            end
        end

        r.record_type = c.type_code;
        if (last_byte) begin
            r.message_end = 1'b1;
            r.message_ok  = c.complete && !c.reject;
            c             = CTL_RESET;
            len           = '0;
        end

        ctl_next = c;
        len_next = len;
        res_next = r;
    end

endmodule

`default_nettype wire

>>> sv/replication_record_parser.sv
`default_nettype none

// replication record parser
// input channel (s_): one message byte per beat, s_last_byte marks the final
// byte of a message. the first byte picks the record type, then the type's
// fields (hash, varint-prefixed blobs, record key) are walked byte by byte.
// output channel (m_): exactly one result beat per input beat, carrying the
// field byte and its kind, field end/empty flags, the record type and, on
// the last byte, message_end with accept (message_ok) or reject.
// each result beat is registered and appears in the cycle after its input
// byte is taken. throughput: one byte per cycle while the receiver does not stall.
// the receiver may stall: the result register holds its beat and a new byte
// is taken in the same cycle the held one is taken; with the result register
// full and m_ready low, s_ready is low.
// reset (aresetn low, synchronous): parse state returns to waiting for a
// type byte and the result register empties.
module replication_record_parser #(
    parameter int KEY_BYTES  = rrp_pkg::KEY_BYTES_DEF,
    parameter int HASH_BYTES = rrp_pkg::HASH_BYTES_DEF,
    parameter int LEN_BITS   = rrp_pkg::LEN_BITS_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [7:0]  s_data_byte,
    input  wire        s_last_byte,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_field_byte,
    output logic       m_field_valid,
    output logic [1:0] m_field_kind,
    output logic       m_field_end,
    output logic       m_field_empty,
    output logic [2:0] m_record_type,
    output logic       m_message_end,
    output logic       m_message_ok
);
    import rrp_pkg::*;

    ctl_t                ctl_reg;
    ctl_t                ctl_next;
    logic [LEN_BITS-1:0] len_reg;
    logic [LEN_BITS-1:0] len_next;
    result_t             res_reg;
    result_t             res_next;
    logic                m_valid_reg;
    logic                s_accept;

    rrp_step #(
        .KEY_BYTES  (KEY_BYTES),
        .HASH_BYTES (HASH_BYTES),
        .LEN_BITS   (LEN_BITS)
    ) u_step (
        .ctl_cur   (ctl_reg),
        .len_cur   (len_reg),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .ctl_next  (ctl_next),
        .len_next  (len_next),
        .res_next  (res_next)
    );

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg     <= CTL_RESET;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                ctl_reg     <= ctl_next;
                len_reg     <= len_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_field_byte  = res_reg.field_byte;
    assign m_field_valid = res_reg.field_valid;
    assign m_field_kind  = res_reg.field_kind;
    assign m_field_end   = res_reg.field_end;
    assign m_field_empty = res_reg.field_empty;
    assign m_record_type = res_reg.record_type;
    assign m_message_end = res_reg.message_end;
    assign m_message_ok  = res_reg.message_ok;

    a_ok_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_message_ok) |-> m_message_end)
        else $error("message_ok without message_end");

    a_empty_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_field_empty) |-> (m_field_end && !m_field_valid))
        else $error("field_empty without field_end or with a payload byte");

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_last_byte) |=> (ctl_reg == CTL_RESET && len_reg == '0))
        else $error("parse state not cleared after last byte");

    a_type_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_record_type <= TY_N))
        else $error("record_type out of range");

endmodule

`default_nettype wire

>>> sim/record_parse_checker.sv
`timescale 1ns / 1ps

module record_parse_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_field_byte,
    input  logic       m_field_valid,
    input  logic [1:0] m_field_kind,
    input  logic       m_field_end,
    input  logic       m_field_empty,
    input  logic [2:0] m_record_type,
    input  logic       m_message_end,
    input  logic       m_message_ok,
    output int         errors,
    output int         pending
);
    import rrp_pkg::*;

    localparam int NO_FIELD = 4;
    localparam logic [LEN_BITS_DEF-1:0] LEN_SAT = '1;

    phase_t                  ph;
    logic [2:0]              rec_type;
    logic [1:0]              field_idx;
    logic [LEN_BITS_DEF-1:0] blob_len;
    logic [COUNT_W-1:0]      fixed_cnt;
    logic                    dropped;
    logic                    done;

    result_t parsed_q[$];
    int      fail_count = 0;

    assign errors = fail_count;

    function automatic void clear_parse();
        ph        = PH_TYPE;
        rec_type  = TY_S;
        field_idx = 2'd0;
        blob_len  = '0;
        fixed_cnt = '0;
        dropped   = 1'b0;
        done      = 1'b0;
    endfunction

    // field kind at a position of the current record's layout
    function automatic int kind_at(logic [1:0] st);
        int k;
        k = NO_FIELD;
        case (rec_type)
            TY_S: begin
                if (st == 2'd0) k = FK_HASH;
                else if (st == 2'd1) k = FK_VALUE;
            end
            TY_P: begin
                if (st == 2'd0) k = FK_NAME;
                else if (st == 2'd1) k = FK_KEY;
                else if (st == 2'd2) k = FK_VALUE;
            end
            TY_L, TY_K: begin
                if (st == 2'd0) k = FK_NAME;
                else if (st == 2'd1) k = FK_KEY;
            end
            TY_R, TY_N: begin
                if (st == 2'd0) k = FK_NAME;
            end
            default: k = NO_FIELD;
        endcase
        return k;
    endfunction

    function automatic void start_field();
        int k;
        k = kind_at(field_idx);
        if (k == NO_FIELD) begin
            done = 1'b1;
        end else if (k == FK_NAME || k == FK_VALUE) begin
            ph       = PH_VARINT;
            blob_len = '0;
        end else begin
            ph        = PH_FIXED;
            fixed_cnt = '0;
        end
    endfunction

    function automatic void advance_field();
        field_idx = field_idx + 2'd1;
        start_field();
    endfunction

    function automatic result_t parse_byte(logic [7:0] x, logic last);
        result_t    r;
        int         k;
        logic [2:0] t;
        logic       known;
        r = '0;
        if (!dropped && !done) begin
            k = kind_at(field_idx);
            case (ph)
                PH_TYPE: begin
                    known = 1'b1;
                    t     = TY_S;
                    case (x)
                        CH_S:    t = TY_S;
                        CH_P:    t = TY_P;
                        CH_L:    t = TY_L;
                        CH_K:    t = TY_K;
                        CH_R:    t = TY_R;
                        CH_N:    t = TY_N;
                        default: known = 1'b0;
                    endcase
                    if (!known) begin
                        rec_type = TY_S;
                        dropped  = 1'b1;
                    end else begin
                        rec_type  = t;
                        field_idx = 2'd0;
                        start_field();
                    end
                end
                PH_VARINT: begin
                    if (blob_len > (LEN_SAT >> 7)) blob_len = LEN_SAT;
                    else blob_len = (blob_len << 7) | x[6:0];
                    if (!x[7]) begin
                        if (blob_len == 0) begin
                            r.field_end   = 1'b1;
                            r.field_empty = 1'b1;
                            r.field_kind  = k[1:0];
                            advance_field();
                        end else begin
                            ph = PH_BLOB;
                        end
                    end
                end
                PH_BLOB: begin
                    r.field_valid = 1'b1;
                    r.field_byte  = x;
                    r.field_kind  = k[1:0];
                    blob_len      = blob_len - 1'b1;
                    if (blob_len == 0) begin
                        r.field_end = 1'b1;
                        advance_field();
                    end
                end
                PH_FIXED: begin
                    r.field_valid = 1'b1;
                    r.field_byte  = x;
                    r.field_kind  = k[1:0];
                    fixed_cnt     = fixed_cnt + 1'b1;
                    if (fixed_cnt >= ((k == FK_HASH) ? HASH_BYTES_DEF : KEY_BYTES_DEF)) begin
                        r.field_end = 1'b1;
                        advance_field();
                    end
                end
                default: dropped = 1'b1;
            endcase
            // blob cut short by the end of the message
            if (last && !dropped && !done && ph == PH_BLOB) begin
                r.field_end   = 1'b1;
                r.field_kind  = k[1:0];
                r.field_empty = !r.field_valid;
                if (kind_at(field_idx + 2'd1) == NO_FIELD) done = 1'b1;
            end
        end
        r.record_type = rec_type;
        if (last) begin
            r.message_end = 1'b1;
            r.message_ok  = done && !dropped;
            clear_parse();
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        result_t want;
        if (!aresetn) begin
            clear_parse();
            parsed_q.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (parsed_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    fail_count++;
                end else begin
                    want = parsed_q.pop_front();
                    check_field("field_byte", want.field_byte, m_field_byte);
                    check_field("field_valid", want.field_valid, m_field_valid);
                    check_field("field_kind", want.field_kind, m_field_kind);
                    check_field("field_end", want.field_end, m_field_end);
                    check_field("field_empty", want.field_empty, m_field_empty);
                    check_field("record_type", want.record_type, m_record_type);
                    check_field("message_end", want.message_end, m_message_end);
                    check_field("message_ok", want.message_ok, m_message_ok);
                end
            end
            if (s_valid && s_ready) parsed_q.push_back(parse_byte(s_data_byte, s_last_byte));
            pending <= parsed_q.size();
        end
    end

endmodule

>>> sim/tb_replication_record_parser.sv
`timescale 1ns / 1ps

module tb_replication_record_parser;
    import rrp_pkg::*;

    localparam int STALL_LIMIT     = 5000;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int ITEMS_PER_PHASE = 410;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte   = 8'h00;
    logic       s_last_byte   = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_field_byte;
    logic       m_field_valid;
    logic [1:0] m_field_kind;
    logic       m_field_end;
    logic       m_field_empty;
    logic [2:0] m_record_type;
    logic       m_message_end;
    logic       m_message_ok;

    int   errors;
    int   pending;
    int   tx_idle_pct = 17;
    int   rx_idle_pct = 54;
    bit   rx_hold     = 1'b0;
    int   bytes_sent  = 0;
    logic [7:0] msg[$];

    replication_record_parser dut (.*);

    record_parse_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("[replication_record_parser] ERROR");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, logic l);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= l;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic void add_varint(logic [31:0] n);
        logic [7:0] digits[$];
        digits.push_front({1'b0, n[6:0]});
        n = n >> 7;
        while (n != 0) begin
            digits.push_front({1'b1, n[6:0]});
            n = n >> 7;
        end
        // redundant leading zero digit
        if ($urandom_range(15) == 0) digits.push_front(8'h80);
        foreach (digits[i]) msg.push_back(digits[i]);
    endfunction

    function automatic void add_fixed(int count);
        repeat (count) msg.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void add_blob();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) begin
            // length saturates, blob runs to the end of the message
            repeat (5) msg.push_back(8'hFF);
            msg.push_back(8'h7F);
            add_fixed($urandom_range(3));
        end else if (pick < 3) begin
            pick = $urandom_range(160, 128);
            add_varint(pick);
            add_fixed(pick);
        end else begin
            pick = $urandom_range(6);
            add_varint(pick);
            add_fixed(pick);
        end
    endfunction

    function automatic void build_message();
        int         dmg;
        int         keep;
        logic [7:0] b;
        msg.delete();
        case ($urandom_range(5))
            0: begin
                msg.push_back(CH_S);
                add_fixed(HASH_BYTES_DEF);
                add_blob();
            end
            1: begin
                msg.push_back(CH_P);
                add_blob();
                add_fixed(KEY_BYTES_DEF);
                add_blob();
            end
            2: begin
                msg.push_back(CH_L);
                add_blob();
                add_fixed(KEY_BYTES_DEF);
            end
            3: begin
                msg.push_back(CH_K);
                add_blob();
                add_fixed(KEY_BYTES_DEF);
            end
            4: begin
                msg.push_back(CH_R);
                add_blob();
            end
            default: begin
                msg.push_back(CH_N);
                add_blob();
            end
        endcase
        if ($urandom_range(3) == 0) add_fixed($urandom_range(3, 1));
        dmg = $urandom_range(99);
        if (dmg < 22) begin
            keep = $urandom_range(msg.size(), 1);
            while (msg.size() > keep) void'(msg.pop_back());
        end else if (dmg < 27) begin
            do b = 8'($urandom_range(255));
            while (b == CH_S || b == CH_P || b == CH_L || b == CH_K || b == CH_R || b == CH_N);
            msg[0] = b;
        end else if (dmg < 31) begin
            msg.delete();
            add_fixed($urandom_range(6, 1));
        end
    endfunction

    task automatic run_phase(int tx_pct, int rx_pct);
        int start;
        int n_msgs;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start  = bytes_sent;
        n_msgs = 0;
        while (bytes_sent - start < ITEMS_PER_PHASE) begin
            if (n_msgs == 4) rx_hold = 1'b1;
            if (n_msgs == 9) wait_results_done();
            build_message();
            send_message();
            n_msgs++;
        end
        wait_results_done();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero-length name
        msg = {CH_N, 8'h00};
        send_message();
        // name cut by the message end
        msg = {CH_R, 8'h02, 8'h61};
        send_message();
        // record key missing
        msg = {CH_K, 8'h01, 8'hFF};
        send_message();
        // unknown type bytes
        msg = {8'h00};
        send_message();
        msg = {8'hFF, CH_S};
        send_message();
        // truncated length
        msg = {CH_L, 8'h80};
        send_message();
        // saturating length
        msg = {CH_N, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h01};
        send_message();
        // trailing byte after the last field
        msg = {CH_R, 8'h01, 8'h78, 8'hAA};
        send_message();

        run_phase(17, 54);
        run_phase(54, 17);
        run_phase(0, 0);

        repeat (8) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("[replication_record_parser] OK");
        end else begin
            $display("[replication_record_parser] ERROR");
        end
        $finish;
    end

endmodule
